@@ hdl/assert_macros.svh @@
// assertion macros used by the checker file spi_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/spi_pkg.sv @@
// types and constants of the scintillator pulse integrator
`default_nettype none
package spi_pkg;

   localparam int CHAN_W      = 6;
   localparam int Q_W         = 20;
   localparam int GAIN_W      = 16;
   localparam int TOFF_W      = 8;
   localparam int WIN_W       = 7;
   localparam int SUM_W       = 27;
   localparam int AMP_W       = 21;
   localparam int PE_W        = 32;
   localparam int EN_W        = 34;
   localparam int CNT_W       = 8;
   localparam int START_W     = 8;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 8;

   localparam int MAX_SAMPLES  = 256;
   localparam int MAX_CHANNELS = 64;
   localparam int IDX_W        = $clog2(MAX_SAMPLES + 1);
   localparam int POS_W        = ((IDX_W > 9) ? IDX_W : 9) + 2;
   localparam int MAXCH_W      = $clog2(MAX_CHANNELS + 1);

   localparam int SCALE_W     = 17;
   localparam int PROD_W      = SUM_W + SCALE_W;
   localparam int DIV_STEPS   = PROD_W;
   localparam int DIVCNT_W    = $clog2(DIV_STEPS);

   localparam logic [SCALE_W-1:0]      PE_SCALE   = 17'd100000;
   localparam logic signed [AMP_W-1:0] PEAK_RESET = -21'sd15984;
   localparam logic [21:0]             EVPED_LIMIT = 22'd240;
   localparam logic [CNT_W-1:0]        TCNT_LOW   = 8'd1;
   localparam logic [CNT_W-1:0]        TCNT_HIGH  = 8'd10;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START_SAMPLE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PULSE_WIDTH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH_LYSO   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INSTR_CHAN   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CLEAN_MODE   = 3'd4;

   typedef struct packed {
      logic sample_en;
      logic load_mult;
      logic div_step;
      logic finish;
   } spi_cmd_type;

   typedef struct packed {
      logic last_hit;
   } spi_status_type;

endpackage
`default_nettype wire

@@ hdl/scintillator_pulse_integrator.sv @@
// Scintillator pulse integrator, top level. Charge samples of one channel are
// taken one per clock while req_ready is high; the word flagged last closes the
// channel. For the last word of an instrumented channel the block stops taking
// samples: state ST_MUL forms the 44-bit charge product, a restoring divider in
// ST_DIV then produces one quotient bit per cycle, ST_FIN saturates and registers
// photoelectrons and energy, and the result word is then held on the rsp_ port
// until taken. Sample input resumes the cycle after. The last word of a channel
// at or above the instrumented-channel setting does not stop sample input.
// Configuration is written at index csr_index through csr_we and csr_wdata; the
// user must do so only while the block is idle; the block does not enforce this.
`default_nettype none
module scintillator_pulse_integrator (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic [spi_pkg::CHAN_W-1:0]             req_channel,
   input  wire logic signed [spi_pkg::Q_W-1:0]         req_charge,
   input  wire logic signed [spi_pkg::Q_W-1:0]         req_pedestal,
   input  wire logic signed [spi_pkg::Q_W-1:0]         req_event_pedestal,
   input  wire logic [spi_pkg::GAIN_W-1:0]             req_gain,
   input  wire logic signed [spi_pkg::TOFF_W-1:0]      req_time_offset,
   input  wire logic                                   req_last,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic [spi_pkg::CHAN_W-1:0]                  rsp_bar,
   output logic [spi_pkg::WIN_W-1:0]                   rsp_window_used,
   output logic [spi_pkg::SUM_W-1:0]                   rsp_total_charge,
   output logic signed [spi_pkg::AMP_W-1:0]            rsp_amplitude,
   output logic [spi_pkg::PE_W-1:0]                    rsp_photoelectrons,
   output logic [spi_pkg::EN_W-1:0]                    rsp_energy,
   output logic [spi_pkg::CNT_W-1:0]                   rsp_above_pedestal_count,
   output logic [spi_pkg::CNT_W-1:0]                   rsp_above_threshold_count,
   output logic                                        rsp_clean,
   input  wire logic                                   csr_we,
   input  wire logic [spi_pkg::CSR_IDX_W-1:0]          csr_index,
   input  wire logic [spi_pkg::CSR_DATA_W-1:0]         csr_wdata
);
   import spi_pkg::*;

   spi_cmd_type    cmd;
   spi_status_type status;

   spi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   spi_datapath u_datapath (
      .clock                     (clock),
      .reset                     (reset),
      .cmd                       (cmd),
      .status                    (status),
      .csr_we                    (csr_we),
      .csr_index                 (csr_index),
      .csr_wdata                 (csr_wdata),
      .req_channel               (req_channel),
      .req_charge                (req_charge),
      .req_pedestal              (req_pedestal),
      .req_event_pedestal        (req_event_pedestal),
      .req_gain                  (req_gain),
      .req_time_offset           (req_time_offset),
      .req_last                  (req_last),
      .rsp_bar                   (rsp_bar),
      .rsp_window_used           (rsp_window_used),
      .rsp_total_charge          (rsp_total_charge),
      .rsp_amplitude             (rsp_amplitude),
      .rsp_photoelectrons        (rsp_photoelectrons),
      .rsp_energy                (rsp_energy),
      .rsp_above_pedestal_count  (rsp_above_pedestal_count),
      .rsp_above_threshold_count (rsp_above_threshold_count),
      .rsp_clean                 (rsp_clean)
   );

endmodule
`default_nettype wire

@@ hdl/spi_ctrl.sv @@
// sequencing state machine of the pulse integrator
`default_nettype none
module spi_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  spi_pkg::spi_status_type   status,
   output spi_pkg::spi_cmd_type      cmd
);
   import spi_pkg::*;

   typedef enum logic [4:0] {
      ST_RUN  = 5'b00001,
      ST_MUL  = 5'b00010,
      ST_DIV  = 5'b00100,
      ST_FIN  = 5'b01000,
      ST_HOLD = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic [DIVCNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         ST_RUN: begin
            cmd.sample_en = req_valid;
            if (req_valid && status.last_hit) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.load_mult = 1'b1;
            cnt_in        = '0;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == DIVCNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_FIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_FIN: begin
            cmd.finish = 1'b1;
            state_in   = ST_HOLD;
         end
         ST_HOLD: begin
            if (rsp_ready) begin
               state_in = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   assign req_ready = (state_ff == ST_RUN);
   assign rsp_valid = (state_ff == ST_HOLD);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule
`default_nettype wire

@@ hdl/spi_datapath.sv @@
// sample accumulation, quality test and photoelectron divider
`default_nettype none
module spi_datapath (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  spi_pkg::spi_cmd_type                        cmd,
   output spi_pkg::spi_status_type                     status,
   input  wire logic                                   csr_we,
   input  wire logic [spi_pkg::CSR_IDX_W-1:0]          csr_index,
   input  wire logic [spi_pkg::CSR_DATA_W-1:0]         csr_wdata,
   input  wire logic [spi_pkg::CHAN_W-1:0]             req_channel,
   input  wire logic signed [spi_pkg::Q_W-1:0]         req_charge,
   input  wire logic signed [spi_pkg::Q_W-1:0]         req_pedestal,
   input  wire logic signed [spi_pkg::Q_W-1:0]         req_event_pedestal,
   input  wire logic [spi_pkg::GAIN_W-1:0]             req_gain,
   input  wire logic signed [spi_pkg::TOFF_W-1:0]      req_time_offset,
   input  wire logic                                   req_last,
   output logic [spi_pkg::CHAN_W-1:0]                  rsp_bar,
   output logic [spi_pkg::WIN_W-1:0]                   rsp_window_used,
   output logic [spi_pkg::SUM_W-1:0]                   rsp_total_charge,
   output logic signed [spi_pkg::AMP_W-1:0]            rsp_amplitude,
   output logic [spi_pkg::PE_W-1:0]                    rsp_photoelectrons,
   output logic [spi_pkg::EN_W-1:0]                    rsp_energy,
   output logic [spi_pkg::CNT_W-1:0]                   rsp_above_pedestal_count,
   output logic [spi_pkg::CNT_W-1:0]                   rsp_above_threshold_count,
   output logic                                        rsp_clean
);
   import spi_pkg::*;

   // configuration
   logic [START_W-1:0] start_ff;
   logic [WIN_W-1:0]   width_ff;
   logic [WIN_W-1:0]   width_lyso_ff;
   logic [WIN_W-1:0]   instr_ff;
   logic               clean_mode_ff;

   // per-channel state
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic                    stopped_ff, stopped_in;
   logic [SUM_W-1:0]        sum_ff, sum_in;
   logic signed [AMP_W-1:0] peak_ff, peak_in;
   logic [CNT_W-1:0]        pcnt_ff, pcnt_in;
   logic [CNT_W-1:0]        tcnt_ff, tcnt_in;

   // result and divider
   logic [CHAN_W-1:0]       res_bar_ff;
   logic [WIN_W-1:0]        res_width_ff;
   logic [SUM_W-1:0]        res_sum_ff;
   logic signed [AMP_W-1:0] res_peak_ff;
   logic [CNT_W-1:0]        res_pcnt_ff;
   logic [CNT_W-1:0]        res_tcnt_ff;
   logic signed [Q_W-1:0]   res_evped_ff;
   logic [GAIN_W-1:0]       res_gain_ff;
   logic                    res_clean_ff;
   logic [PROD_W-1:0]       dq_ff;
   logic [GAIN_W-1:0]       rem_ff;
   logic [PE_W-1:0]         pe_ff;
   logic [EN_W-1:0]         energy_ff;

   logic [WIN_W-1:0]        width_sel;
   logic signed [POS_W-1:0] start_pos;
   logic signed [POS_W-1:0] idx_pos;
   logic signed [POS_W-1:0] pos;
   logic                    active;
   logic                    in_window;
   logic signed [AMP_W-1:0] ped_ext;
   logic signed [AMP_W-1:0] excess;
   logic signed [AMP_W-1:0] aped;
   logic signed [23:0]      aped_ext;
   logic signed [23:0]      thr;
   logic                    exc_pos;
   logic                    exc_thr;
   logic [SUM_W:0]          sum_add;
   logic                    instrumented;

   logic signed [22:0]      peak3;
   logic signed [29:0]      sum2;
   logic signed [21:0]      ev_ext;
   logic [21:0]             aev;
   logic                    clean_calc;

   logic [GAIN_W:0]         trial;
   logic                    trial_ge;
   logic [PE_W-1:0]         pe_calc;

   always_comb begin
      width_sel = req_channel[0] ? width_ff : width_lyso_ff;
      start_pos = POS_W'(start_ff) + POS_W'(req_time_offset);
      idx_pos   = POS_W'(idx_ff);
      pos       = idx_pos - start_pos;
      active    = !stopped_ff && (idx_ff < IDX_W'(MAX_SAMPLES)) && (idx_pos >= start_pos);
      in_window = pos < $signed(POS_W'(width_sel));

      ped_ext  = AMP_W'(req_pedestal);
      excess   = AMP_W'(req_charge) - ped_ext;
      aped     = ped_ext[AMP_W-1] ? -ped_ext : ped_ext;
      aped_ext = 24'(aped);
      thr      = clean_mode_ff ? ((aped_ext <<< 3) + (aped_ext <<< 1)) : aped_ext;
      exc_pos  = excess > 0;
      exc_thr  = 24'(excess) > thr;
      sum_add  = {1'b0, sum_ff} + (SUM_W + 1)'(excess[Q_W-1:0]);

      instrumented = ({1'b0, req_channel} < instr_ff) &&
                     (MAXCH_W'(req_channel) < MAXCH_W'(MAX_CHANNELS));

      idx_in     = idx_ff;
      stopped_in = stopped_ff;
      sum_in     = sum_ff;
      peak_in    = peak_ff;
      pcnt_in    = pcnt_ff;
      tcnt_in    = tcnt_ff;
      if (active) begin
         if (exc_pos && (pcnt_ff != '1)) begin
            pcnt_in = pcnt_ff + 1'b1;
         end
         if (exc_thr && (tcnt_ff != '1)) begin
            tcnt_in = tcnt_ff + 1'b1;
         end
         if (in_window) begin
            if (excess > peak_ff) begin
               peak_in = excess;
            end
            if (exc_pos) begin
               sum_in = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
            end
         end else if (exc_pos == 1'b0 && excess != 0 || req_charge[Q_W-1]) begin
            stopped_in = 1'b1;
         end
      end
      if (idx_ff < IDX_W'(MAX_SAMPLES)) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   assign status.last_hit = req_last && instrumented;

   // clean-hit test on the captured channel
   always_comb begin
      peak3      = 23'(res_peak_ff) + (23'(res_peak_ff) <<< 1);
      sum2       = $signed({2'b00, res_sum_ff, 1'b0});
      ev_ext     = 22'(res_evped_ff);
      aev        = ev_ext[21] ? 22'(-ev_ext) : 22'(ev_ext);
      clean_calc = clean_mode_ff && (30'(peak3) < sum2) && (aev < EVPED_LIMIT) &&
                   (res_tcnt_ff > TCNT_LOW) && (res_tcnt_ff < TCNT_HIGH);
   end

   // one quotient bit per step
   always_comb begin
      trial    = {rem_ff, dq_ff[PROD_W-1]};
      trial_ge = trial >= {1'b0, res_gain_ff};
      if (res_gain_ff == '0) begin
         pe_calc = (res_sum_ff != '0) ? '1 : '0;
      end else if (dq_ff[PROD_W-1:PE_W] != '0) begin
         pe_calc = '1;
      end else begin
         pe_calc = dq_ff[PE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff      <= '0;
         width_ff      <= 7'd5;
         width_lyso_ff <= 7'd8;
         instr_ff      <= 7'd16;
         clean_mode_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_START_SAMPLE: start_ff      <= csr_wdata[START_W-1:0];
            CSR_PULSE_WIDTH:  width_ff      <= csr_wdata[WIN_W-1:0];
            CSR_WIDTH_LYSO:   width_lyso_ff <= csr_wdata[WIN_W-1:0];
            CSR_INSTR_CHAN:   instr_ff      <= csr_wdata[WIN_W-1:0];
            CSR_CLEAN_MODE:   clean_mode_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (cmd.sample_en && req_last)) begin
         idx_ff     <= '0;
         stopped_ff <= 1'b0;
         sum_ff     <= '0;
         peak_ff    <= PEAK_RESET;
         pcnt_ff    <= '0;
         tcnt_ff    <= '0;
      end else if (cmd.sample_en) begin
         idx_ff     <= idx_in;
         stopped_ff <= stopped_in;
         sum_ff     <= sum_in;
         peak_ff    <= peak_in;
         pcnt_ff    <= pcnt_in;
         tcnt_ff    <= tcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sample_en && status.last_hit) begin
         res_bar_ff   <= req_channel;
         res_width_ff <= width_sel;
         res_sum_ff   <= sum_in;
         res_peak_ff  <= peak_in;
         res_pcnt_ff  <= pcnt_in;
         res_tcnt_ff  <= tcnt_in;
         res_evped_ff <= req_event_pedestal;
         res_gain_ff  <= req_gain;
      end
      if (cmd.load_mult) begin
         dq_ff        <= PROD_W'(res_sum_ff) * PROD_W'(PE_SCALE);
         rem_ff       <= '0;
         res_clean_ff <= clean_calc;
      end else if (cmd.div_step) begin
         dq_ff  <= {dq_ff[PROD_W-2:0], trial_ge};
         rem_ff <= trial_ge ? GAIN_W'(trial - {1'b0, res_gain_ff}) : trial[GAIN_W-1:0];
      end
      if (cmd.finish) begin
         pe_ff     <= pe_calc;
         energy_ff <= EN_W'(pe_calc) + (EN_W'(pe_calc) << 1);
      end
   end

   assign rsp_bar                   = res_bar_ff;
   assign rsp_window_used           = res_width_ff;
   assign rsp_total_charge          = res_sum_ff;
   assign rsp_amplitude             = res_peak_ff;
   assign rsp_photoelectrons        = pe_ff;
   assign rsp_energy                = energy_ff;
   assign rsp_above_pedestal_count  = res_pcnt_ff;
   assign rsp_above_threshold_count = res_tcnt_ff;
   assign rsp_clean                 = res_clean_ff;

endmodule
`default_nettype wire

@@ hdl/spi_checker.sv @@
// port-level checks of the pulse integrator and their binding
`default_nettype none
`include "assert_macros.svh"
module spi_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_ready,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_ready,
   input wire logic [spi_pkg::PE_W-1:0]           rsp_photoelectrons,
   input wire logic [spi_pkg::EN_W-1:0]           rsp_energy,
   input wire logic [spi_pkg::CNT_W-1:0]          rsp_above_threshold_count,
   input wire logic                               rsp_clean
);
   import spi_pkg::*;

   `CHK_IMPLY(a_no_overlap, clock, reset, rsp_valid, !req_ready, "input open while word held")
   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_energy), "stalled word changed")
   `CHK_IMPLY(a_energy, clock, reset, rsp_valid, rsp_energy == EN_W'(rsp_photoelectrons) * EN_W'(3), "energy not three times pe")
   `CHK_IMPLY(a_clean_cnt, clock, reset, rsp_valid && rsp_clean, rsp_above_threshold_count > TCNT_LOW && rsp_above_threshold_count < TCNT_HIGH, "clean with bad count")
   `CHK_NEXT(a_resume, clock, reset, rsp_valid && rsp_ready, req_ready, "input not reopened")

endmodule

bind scintillator_pulse_integrator spi_checker u_spi_checker (
   .clock                     (clock),
   .reset                     (reset),
   .req_ready                 (req_ready),
   .rsp_valid                 (rsp_valid),
   .rsp_ready                 (rsp_ready),
   .rsp_photoelectrons        (rsp_photoelectrons),
   .rsp_energy                (rsp_energy),
   .rsp_above_threshold_count (rsp_above_threshold_count),
   .rsp_clean                 (rsp_clean)
);
`default_nettype wire

@@ tb/scintillator_pulse_integrator_test.sv @@
// self-checking testbench of the scintillator pulse integrator
`default_nettype none
module scintillator_pulse_integrator_test;
   import spi_pkg::*;

   localparam int QUIET_LIMIT = 1500;
   localparam int DRAIN_CYCLES = 64;
   localparam int PHASES = 10;
   localparam longint PEAK_EMPTY = -15984;
   localparam longint SUM_SAT = 134217727;
   localparam int COUNT_SAT = 255;
   localparam logic [63:0] PE_SAT = 64'hFFFF_FFFF;
   localparam logic [63:0] PE_FACTOR = 64'd100000;
   localparam longint EVPED_CUT = 240;
   localparam int THR_COUNT_MIN = 1;
   localparam int THR_COUNT_MAX = 10;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 3'd7;

   typedef struct {
      logic [CHAN_W-1:0] channel;
      logic signed [Q_W-1:0] charge;
      logic signed [Q_W-1:0] pedestal;
      logic signed [Q_W-1:0] event_pedestal;
      logic [GAIN_W-1:0] gain;
      logic signed [TOFF_W-1:0] time_offset;
      logic last;
   } sample_word_type;

   typedef struct {
      logic [CHAN_W-1:0] bar;
      logic [WIN_W-1:0] window_used;
      logic [SUM_W-1:0] total_charge;
      logic signed [AMP_W-1:0] amplitude;
      logic [PE_W-1:0] photoelectrons;
      logic [EN_W-1:0] energy;
      logic [CNT_W-1:0] above_pedestal_count;
      logic [CNT_W-1:0] above_threshold_count;
      logic clean;
   } hit_word_type;

   typedef enum {RX_OPEN, RX_COIN, RX_STALLS} rx_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [CHAN_W-1:0] req_channel = '0;
   logic signed [Q_W-1:0] req_charge = '0;
   logic signed [Q_W-1:0] req_pedestal = '0;
   logic signed [Q_W-1:0] req_event_pedestal = '0;
   logic [GAIN_W-1:0] req_gain = '0;
   logic signed [TOFF_W-1:0] req_time_offset = '0;
   logic req_last = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [CHAN_W-1:0] rsp_bar;
   logic [WIN_W-1:0] rsp_window_used;
   logic [SUM_W-1:0] rsp_total_charge;
   logic signed [AMP_W-1:0] rsp_amplitude;
   logic [PE_W-1:0] rsp_photoelectrons;
   logic [EN_W-1:0] rsp_energy;
   logic [CNT_W-1:0] rsp_above_pedestal_count;
   logic [CNT_W-1:0] rsp_above_threshold_count;
   logic rsp_clean;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // predictor copy of the registers
   logic [START_W-1:0] start_cfg = 8'd0;
   logic [WIN_W-1:0] pw_cfg = 7'd5;
   logic [WIN_W-1:0] lyso_cfg = 7'd8;
   logic [WIN_W-1:0] instr_cfg = 7'd16;
   logic clean_cfg = 1'b0;

   // predictor copy of the channel state
   int ch_index = 0;
   bit ch_stopped = 1'b0;
   longint ch_sum = 0;
   longint ch_peak = PEAK_EMPTY;
   int ch_pcount = 0;
   int ch_tcount = 0;

   sample_word_type sample_q[$];
   hit_word_type hit_q[$];

   int mismatches = 0;
   int words_queued = 0;
   int words_taken = 0;
   int hits_seen = 0;
   int settings_run = 0;
   int quiet_cycles = 0;
   int burst_left = 0;
   int gap_left = 0;
   int rx_left = 0;
   int rx_hold = 0;
   rx_mode_type rx_mode = RX_OPEN;

   scintillator_pulse_integrator dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_channel(req_channel),
      .req_charge(req_charge),
      .req_pedestal(req_pedestal),
      .req_event_pedestal(req_event_pedestal),
      .req_gain(req_gain),
      .req_time_offset(req_time_offset),
      .req_last(req_last),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_bar(rsp_bar),
      .rsp_window_used(rsp_window_used),
      .rsp_total_charge(rsp_total_charge),
      .rsp_amplitude(rsp_amplitude),
      .rsp_photoelectrons(rsp_photoelectrons),
      .rsp_energy(rsp_energy),
      .rsp_above_pedestal_count(rsp_above_pedestal_count),
      .rsp_above_threshold_count(rsp_above_threshold_count),
      .rsp_clean(rsp_clean),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   task automatic report_mismatch(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
   endtask

   task automatic compare_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want)
         report_mismatch($sformatf("hit %0d %s got %0h want %0h", hits_seen, name, got, want));
   endtask

   function automatic void clear_channel_state();
      ch_index = 0;
      ch_stopped = 1'b0;
      ch_sum = 0;
      ch_peak = PEAK_EMPTY;
      ch_pcount = 0;
      ch_tcount = 0;
   endfunction

   // charge integration of one accepted word, hit queued on the last word of an instrumented channel
   function automatic void integrate_sample(sample_word_type s);
      logic [WIN_W-1:0] width;
      longint start, q, ped, excess, aped, thr, pos, aev;
      logic [63:0] sum_u, pe;
      hit_word_type h;
      width = s.channel[0] ? pw_cfg : lyso_cfg;
      start = longint'(start_cfg) + longint'(s.time_offset);
      q = longint'(s.charge);
      ped = longint'(s.pedestal);
      if (!ch_stopped && ch_index < MAX_SAMPLES && longint'(ch_index) >= start) begin
         excess = q - ped;
         aped = (ped < 0) ? -ped : ped;
         thr = clean_cfg ? 10 * aped : aped;
         pos = longint'(ch_index) - start;
         if (excess > 0 && ch_pcount < COUNT_SAT) ch_pcount++;
         if (excess > thr && ch_tcount < COUNT_SAT) ch_tcount++;
         if (pos < longint'(width)) begin
            if (excess > ch_peak) ch_peak = excess;
            if (excess > 0) begin
               ch_sum += excess;
               if (ch_sum > SUM_SAT) ch_sum = SUM_SAT;
            end
         end else if (excess < 0 || q < 0) begin
            ch_stopped = 1'b1;
         end
      end
      if (ch_index < MAX_SAMPLES) ch_index++;
      if (s.last) begin
         if (int'(s.channel) < int'(instr_cfg) && int'(s.channel) < MAX_CHANNELS) begin
            aev = longint'(s.event_pedestal);
            if (aev < 0) aev = -aev;
            sum_u = ch_sum;
            if (s.gain == 0) begin
               pe = (ch_sum > 0) ? PE_SAT : 64'd0;
            end else begin
               pe = (sum_u * PE_FACTOR) / 64'(s.gain);
               if (pe > PE_SAT) pe = PE_SAT;
            end
            h.bar = s.channel;
            h.window_used = width;
            h.total_charge = sum_u[SUM_W-1:0];
            h.amplitude = ch_peak[AMP_W-1:0];
            h.photoelectrons = pe[PE_W-1:0];
            h.energy = EN_W'(pe * 64'd3);
            h.above_pedestal_count = ch_pcount[CNT_W-1:0];
            h.above_threshold_count = ch_tcount[CNT_W-1:0];
            h.clean = clean_cfg && (3 * ch_peak < 2 * ch_sum) && (aev < EVPED_CUT) &&
                      (ch_tcount > THR_COUNT_MIN) && (ch_tcount < THR_COUNT_MAX);
            hit_q.insert(hit_q.size(), h);
         end
         clear_channel_state();
      end
   endfunction

   function automatic int clip_charge(int v);
      if (v > 524287) return 524287;
      if (v < -524288) return -524288;
      return v;
   endfunction

   function automatic void queue_word(sample_word_type s);
      sample_q.insert(sample_q.size(), s);
      words_queued++;
   endfunction

   function automatic void directed_word(int ch, int q, int ped, int ev, int gain, int toff,
                                         bit last);
      sample_word_type s;
      s.channel = CHAN_W'(ch);
      s.charge = Q_W'(q);
      s.pedestal = Q_W'(ped);
      s.event_pedestal = Q_W'(ev);
      s.gain = GAIN_W'(gain);
      s.time_offset = TOFF_W'(toff);
      s.last = last;
      queue_word(s);
   endfunction

   function automatic void add_noise(bit force_last);
      sample_word_type s;
      s.channel = CHAN_W'($urandom);
      s.charge = Q_W'($urandom);
      s.pedestal = Q_W'($urandom);
      s.event_pedestal = Q_W'($urandom);
      s.gain = GAIN_W'($urandom);
      s.time_offset = TOFF_W'($urandom);
      s.last = force_last || ($urandom_range(0, 3) == 0);
      queue_word(s);
   endfunction

   // one channel of samples shaped as a pulse around its window
   function automatic void add_channel();
      sample_word_type s;
      int ped, st, width, len, peak, v, p, lim;
      lim = (instr_cfg > MAX_CHANNELS) ? MAX_CHANNELS : int'(instr_cfg);
      if (lim != 0 && $urandom_range(0, 4) != 0) s.channel = CHAN_W'($urandom_range(0, lim - 1));
      else s.channel = CHAN_W'($urandom);
      case ($urandom_range(0, 9))
         0: ped = int'($urandom_range(0, 1048575)) - 524288;
         1: ped = int'($urandom_range(0, 4000)) - 2000;
         default: ped = int'($urandom_range(0, 60)) - 30;
      endcase
      s.pedestal = Q_W'(ped);
      if ($urandom_range(0, 4) == 0) s.event_pedestal = Q_W'($urandom);
      else s.event_pedestal = Q_W'(clip_charge(ped + int'($urandom_range(0, 40)) - 20));
      case ($urandom_range(0, 9))
         0: s.gain = GAIN_W'($urandom_range(0, 3));
         1: s.gain = GAIN_W'($urandom_range(1, 64));
         default: s.gain = GAIN_W'($urandom);
      endcase
      if ($urandom_range(0, 5) == 0) s.time_offset = TOFF_W'($urandom);
      else s.time_offset = TOFF_W'(int'($urandom_range(0, 6)) - 3);
      st = int'(start_cfg) + int'(s.time_offset);
      width = s.channel[0] ? int'(pw_cfg) : int'(lyso_cfg);
      case ($urandom_range(0, 29))
         0: len = $urandom_range(257, 262);
         1, 2: len = $urandom_range(1, 6);
         default: len = ((st > 0) ? st : 0) + width + int'($urandom_range(0, 10));
      endcase
      if (len > 300) len = 300;
      if (len < 1) len = 1;
      peak = ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, 60000)) :
                                           int'($urandom_range(0, 400));
      for (int i = 0; i < len; i++) begin
         p = i - st;
         if (p >= 0 && p < width) begin
            if ($urandom_range(0, 7) == 0) v = ped - int'($urandom_range(0, peak));
            else v = ped + int'($urandom_range(0, peak));
         end else if ($urandom_range(0, 9) == 0) begin
            v = -int'($urandom_range(0, 3000));
         end else begin
            v = ped + int'($urandom_range(0, 30)) - 15;
         end
         s.charge = Q_W'(clip_charge(v));
         s.last = (i == len - 1);
         queue_word(s);
      end
   endfunction

   function automatic void fill_phase(int budget);
      int first;
      first = words_queued;
      while (words_queued - first < budget) begin
         if ($urandom_range(0, 9) == 0) add_noise(1'b0);
         else add_channel();
      end
      add_noise(1'b1);
   endfunction

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_START_SAMPLE: start_cfg = data;
         CSR_PULSE_WIDTH: pw_cfg = data[WIN_W-1:0];
         CSR_WIDTH_LYSO: lyso_cfg = data[WIN_W-1:0];
         CSR_INSTR_CHAN: instr_cfg = data[WIN_W-1:0];
         CSR_CLEAN_MODE: clean_cfg = data[0];
         default: ;
      endcase
   endtask

   task automatic configure(int ph);
      int st, pw, ly, ins, cm;
      case (ph)
         0: begin st = 0; pw = 1; ly = 64; ins = 64; cm = 0; end
         1: begin st = 3; pw = 5; ly = 8; ins = 16; cm = 1; end
         2: begin st = 255; pw = 255; ly = 128; ins = 255; cm = 255; end
         3: begin st = 2; pw = 0; ly = 3; ins = 0; cm = 0; end
         default: begin
            st = $urandom_range(0, 12);
            pw = $urandom_range(1, 16) | ($urandom_range(0, 1) << 7);
            ly = $urandom_range(1, 24) | ($urandom_range(0, 1) << 7);
            ins = $urandom_range(1, 64) | ($urandom_range(0, 1) << 7);
            cm = $urandom_range(0, 1) | ($urandom & 8'hFE);
         end
      endcase
      write_reg(CSR_START_SAMPLE, CSR_DATA_W'(st));
      write_reg(CSR_PULSE_WIDTH, CSR_DATA_W'(pw));
      write_reg(CSR_WIDTH_LYSO, CSR_DATA_W'(ly));
      write_reg(CSR_INSTR_CHAN, CSR_DATA_W'(ins));
      write_reg(CSR_CLEAN_MODE, CSR_DATA_W'(cm));
      if (ph == 0) write_reg(CSR_SPARE, CSR_DATA_W'($urandom));
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic finish_phase();
      while (sample_q.size() != 0 || req_valid) @(posedge clock);
      while (hit_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      settings_run++;
   endtask

   // driver: bursts of words with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) begin
            integrate_sample(sample_q.pop_front());
            words_taken++;
         end
         if (gap_left != 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (sample_q.size() != 0) begin
            req_valid <= 1'b1;
            req_channel <= sample_q[0].channel;
            req_charge <= sample_q[0].charge;
            req_pedestal <= sample_q[0].pedestal;
            req_event_pedestal <= sample_q[0].event_pedestal;
            req_gain <= sample_q[0].gain;
            req_time_offset <= sample_q[0].time_offset;
            req_last <= sample_q[0].last;
            if (burst_left <= 1) begin
               burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200) :
                                                         $urandom_range(1, 30);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
               burst_left--;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rx_left == 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 2));
            rx_left = $urandom_range(64, 512);
         end else begin
            rx_left--;
         end
         case (rx_mode)
            RX_OPEN: rsp_ready <= 1'b1;
            RX_COIN: rsp_ready <= 1'($urandom_range(0, 1));
            default: begin
               if (rx_hold != 0) begin
                  rx_hold--;
                  rsp_ready <= 1'b0;
               end else begin
                  rsp_ready <= 1'b1;
                  if ($urandom_range(0, 3) == 0) rx_hold = $urandom_range(1, 40);
               end
            end
         endcase
      end
   end

   // monitor
   always @(posedge clock) begin : monitor
      hit_word_type h;
      if (!reset && rsp_valid && rsp_ready) begin
         if (hit_q.size() == 0) begin
            report_mismatch($sformatf("unexpected hit on bar %0d", rsp_bar));
         end else begin
            h = hit_q.pop_front();
            compare_field("bar", 64'(rsp_bar), 64'(h.bar));
            compare_field("window_used", 64'(rsp_window_used), 64'(h.window_used));
            compare_field("total_charge", 64'(rsp_total_charge), 64'(h.total_charge));
            compare_field("amplitude", 64'(rsp_amplitude), 64'(h.amplitude));
            compare_field("photoelectrons", 64'(rsp_photoelectrons),
                          64'(h.photoelectrons));
            compare_field("energy", 64'(rsp_energy), 64'(h.energy));
            compare_field("above_pedestal_count", 64'(rsp_above_pedestal_count),
                          64'(h.above_pedestal_count));
            compare_field("above_threshold_count", 64'(rsp_above_threshold_count),
                          64'(h.above_threshold_count));
            compare_field("clean", 64'(rsp_clean), 64'(h.clean));
            hits_seen++;
         end
      end
   end

   // watchdog on cycles without any handshake or register write
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: %0d words and %0d hits still pending",
                     sample_q.size(), hit_q.size());
            $display("scintillator_pulse_integrator_test NOT OK");
            $finish;
         end
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      // full-scale excess twice, saturated photoelectrons
      directed_word(0, 524287, -524288, 0, 1, 0, 1'b0);
      directed_word(0, 524287, -524288, 0, 1, 0, 1'b1);
      // most negative excess, empty sum, largest gain
      directed_word(1, -524288, 524287, -524288, 65535, 0, 1'b1);
      // zero gain with and without charge
      directed_word(2, 100, 0, 0, 0, 0, 1'b1);
      directed_word(3, -5, 0, 0, 0, 0, 1'b1);
      // uninstrumented channel
      directed_word(63, 1000, 0, 0, 100, 0, 1'b1);
      // negative start
      directed_word(5, 200, 10, 5, 16, -128, 1'b0);
      directed_word(5, 300, 10, 5, 16, -128, 1'b0);
      directed_word(5, 50, 10, 5, 16, -128, 1'b1);
      // stop on negative excess after the window
      for (int i = 0; i < 5; i++) directed_word(7, 100, 20, 0, 32, 0, 1'b0);
      directed_word(7, 10, 20, 0, 32, 0, 1'b0);
      directed_word(7, 500, 20, 0, 32, 0, 1'b0);
      directed_word(7, 500, 20, 0, 32, 0, 1'b1);
      // start pushed out by the largest offset
      directed_word(9, 400, 0, 0, 16, 127, 1'b0);
      directed_word(9, 400, 0, 0, 16, 127, 1'b1);
      // channel changes within one sequence
      directed_word(4, 400, 0, 0, 16, 0, 1'b0);
      directed_word(11, 50, 0, 0, 16, 0, 1'b1);
      // instrumented boundary, extreme event pedestal
      directed_word(15, 300, -1, 524287, 16, 0, 1'b1);
      directed_word(16, 300, -1, 0, 16, 0, 1'b1);
      finish_phase();
      for (int ph = 0; ph < PHASES; ph++) begin
         configure(ph);
         @(negedge clock);
         fill_phase((ph == 2) ? 300 : (ph == 3) ? 100 : 200);
         finish_phase();
      end
      $display("run covered %0d words over %0d register settings", words_taken, settings_run);
      $display("%0d hits checked, %0d mismatches", hits_seen, mismatches);
      if (mismatches == 0) begin
         $display("scintillator_pulse_integrator_test OK");
      end else begin
         $display("scintillator_pulse_integrator_test NOT OK");
      end
      $finish;
   end

endmodule
`default_nettype wire

@@ filelist.f @@
+incdir+hdl
hdl/spi_pkg.sv
hdl/spi_ctrl.sv
hdl/spi_datapath.sv
hdl/scintillator_pulse_integrator.sv
hdl/spi_checker.sv
tb/scintillator_pulse_integrator_test.sv
